@@ rtl/lru_key_value_cache_macros.svh @@
// ----------------------------------------------------------------------------
// lru key/value cache assertion macros
// shared property forms for the cache checks, clocked on clock, reset on reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// condition holds at every edge outside reset
`define LKVC_CHECK(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent this edge implies consequent at the next edge
`define LKVC_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// types and constants shared by the lru cache cells and the top level
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [VAL_W-1:0] MISS_VALUE     = 32'hFFFF_FFFF;

   // one stored entry, moves toward the tail as entries age
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   // signals rippling from head to tail during the update cycle
   typedef struct packed {
      logic             pass;
      logic             hit;
      logic [VAL_W-1:0] hit_value;
   } chain_type;

   // control broadcast to every cell
   typedef struct packed {
      logic compare;
      logic commit;
      logic evict;
   } ctl_type;

endpackage

@@ rtl/lkvc_cell.sv @@
// ----------------------------------------------------------------------------
// lkvc_cell
// one recency slot: holds an entry, compares its key, shifts from its neighbor
// ----------------------------------------------------------------------------
module lkvc_cell import lkvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ctl_type          ctl,
   input  logic [KEY_W-1:0] req_key,
   input  entry_type        up_entry,
   input  logic             down_valid,
   input  chain_type        chain_in,
   output chain_type        chain_out,
   output entry_type        entry,
   output logic             match
);

   logic             valid_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic             match_ff;
   logic             match_in;
   logic             stop;
   logic             load;

   assign match_in = valid_ff && (key_ff == req_key);

   // a hit ends the shift here; on eviction the last valid slot is dropped
   assign stop = match_ff || (ctl.evict && valid_ff && !down_valid);
   assign load = ctl.commit && chain_in.pass;

   assign chain_out.pass      = chain_in.pass && !stop;
   assign chain_out.hit       = chain_in.hit || match_ff;
   assign chain_out.hit_value = chain_in.hit_value | (match_ff ? value_ff : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctl.compare) begin
            match_ff <= match_in;
         end
         if (load) begin
            valid_ff <= up_entry.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff   <= up_entry.key;
         value_ff <= up_entry.value;
      end
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.value = value_ff;
   assign match       = match_ff;

endmodule

@@ rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// a get's response is registered when the update state finishes, after the compare state
// one request at a time (accept, compare, shift); a new request is taken only in idle, later while a response waits
// reset: cache empty, entry count zero, capacity 16; no clearing pass
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_write_enable,
   input  logic [CAP_W-1:0]        csr_write_data,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic signed [VAL_W-1:0] req_value,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic signed [VAL_W-1:0] rsp_read_value
);

   // count holds 0..ENTRIES; compare width covers both count and capacity
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // sequencer codes
   localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request transfer
   localparam logic [1:0] S_CMP  = 2'd1;  // every cell compares its key
   localparam logic [1:0] S_UPD  = 2'd2;  // shift the row, load the response

   logic [1:0]       state_ff, state_in;
   logic [CAP_W-1:0] capacity_ff;
   logic [CNT_W-1:0] count_ff;
   logic             mode_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [VAL_W-1:0] rsp_value_ff;

   logic             req_xfer;
   logic             is_put;
   logic             upd_done;
   logic             hit_any;
   logic [VAL_W-1:0] hit_value;
   logic [CMP_W-1:0] cap_raw;
   logic [CMP_W-1:0] cap_eff;
   logic             full;
   ctl_type          ctl;
   entry_type        head_entry;

   // row wiring: cell 0 is the most recent entry, the tail the least recent
   chain_type        chain [ENTRIES+1];
   entry_type        cell_entry [ENTRIES];
   entry_type        up_entry [ENTRIES];
   logic [ENTRIES-1:0] down_valid;
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES-1:0] match_vec;

   assign req_xfer = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign is_put = (mode_ff == MODE_PUT);

   // a get may only finish once the response register is free
   assign upd_done = (state_ff == S_UPD) && (is_put || !rsp_valid_ff || rsp_ready);

   // effective capacity: zero acts as one, above the row size acts as the row size
   assign cap_raw = CMP_W'(capacity_ff);
   always_comb begin
      cap_eff = cap_raw;
      if (cap_raw == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_raw > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end
   assign full = CMP_W'(count_ff) >= cap_eff;

   // hit result comes off the end of the ripple chain
   assign hit_any   = chain[ENTRIES].hit;
   assign hit_value = chain[ENTRIES].hit_value;

   // the row moves on every put, and on a get only when it hits
   assign ctl.compare = (state_ff == S_CMP);
   assign ctl.commit  = upd_done && (is_put || hit_any);
   assign ctl.evict   = is_put && full;

   // new head: the request key, with the put value or the value just read
   assign head_entry.valid = 1'b1;
   assign head_entry.key   = key_ff;
   assign head_entry.value = is_put ? value_ff : hit_value;

   assign chain[0].pass      = 1'b1;
   assign chain[0].hit       = 1'b0;
   assign chain[0].hit_value = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign up_entry[g] = head_entry;
      end else begin : g_body
         assign up_entry[g] = cell_entry[g-1];
      end
      if (g == ENTRIES - 1) begin : g_tail
         assign down_valid[g] = 1'b0;
      end else begin : g_inner
         assign down_valid[g] = cell_entry[g+1].valid;
      end
      assign valid_vec[g] = cell_entry[g].valid;

      lkvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .req_key    (key_ff),
         .up_entry   (up_entry[g]),
         .down_valid (down_valid[g]),
         .chain_in   (chain[g]),
         .chain_out  (chain[g+1]),
         .entry      (cell_entry[g]),
         .match      (match_vec[g])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (upd_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         // only an insert into a free slot grows the count
         if (ctl.commit && is_put && !hit_any && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (upd_done && !is_put) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request and response payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (upd_done && !is_put) begin
         rsp_found_ff <= hit_any;
         rsp_value_ff <= hit_any ? hit_value : MISS_VALUE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   // keys are unique among valid cells, so at most one cell hits
   `LKVC_CHECK(a_single_hit, $onehot0(match_vec), "more than one cell matched the key")
   // valid cells always form an unbroken run from the head
   `LKVC_CHECK(a_valid_prefix, ((valid_vec >> 1) & ~valid_vec) == '0, "gap in valid cells")
   // entry count tracks the number of valid cells
   `LKVC_CHECK(a_count_match, $countones(valid_vec) == int'(count_ff), "count out of step")
   // a finished get always leaves a response waiting
   `LKVC_CHECK_NEXT(a_get_response, upd_done && !is_put, rsp_valid_ff, "get gave no response")

endmodule
